/* hw/rtl/mjpeg_multipart_deframer_macros.svh */
`ifndef MJPEG_MULTIPART_DEFRAMER_MACROS_SVH
`define MJPEG_MULTIPART_DEFRAMER_MACROS_SVH

// Concurrent checks on clk, quiet while rst is high.
`define MJDF_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: forbidden condition seen");

`define MJDF_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication broken");

`define MJDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication broken");

`endif

/* hw/rtl/mjdf_pkg.sv */
package mjdf_pkg;

  localparam int LENGTH_WIDTH_DEFAULT = 24;
  localparam int CFG_WIDTH = 24;
  localparam logic [CFG_WIDTH-1:0] MAX_LEN_RESET = 24'd1000000;

  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_C     = 8'h43;

  localparam logic [3:0] KEY_LEN = 4'd14;

  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic       frame_last;
    logic       length_error;
  } result_t;

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h4C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/mjpeg_multipart_deframer.sv */
// Byte-wide deframer for a multipart MJPEG stream: one byte is taken per cycle
// on in_valid/in_stall, parsed for the "--" boundary, the Content-Length header
// and the blank line, and the declared number of payload bytes leaves on
// out_valid/out_stall with frame_last on the final one; a declared length above
// the max_frame_length register yields one result with length_error set.
// Sustained rate is one byte per cycle while out_stall stays low; a byte reaches
// the output through an input register, the phase update and a two-entry result
// queue that keeps input flowing while a result waits.
// cfg_write loads max_frame_length (reset 1000000) and should be used only
// while the block is idle.
module mjpeg_multipart_deframer #(
  parameter int LENGTH_WIDTH = mjdf_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     payload_byte,
  output logic                           frame_last,
  output logic                           length_error,
  input  logic                           cfg_write,
  input  logic [mjdf_pkg::CFG_WIDTH-1:0] cfg_data
);
  import mjdf_pkg::*;

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s1_fire;
  logic                 q_full;
  logic [CFG_WIDTH-1:0] max_len;
  result_t              res;

  assign s1_fire  = s1_valid && !q_full;
  assign in_stall = s1_valid && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_write) begin
      max_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= in_byte;
    end
  end

  mjdf_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (s1_fire),
    .byte_in (s1_byte),
    .max_len (max_len),
    .res     (res)
  );

  mjdf_out_queue u_out_queue (
    .clk          (clk),
    .rst          (rst),
    .push_res     (res),
    .full         (q_full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .frame_last   (frame_last),
    .length_error (length_error)
  );

endmodule

/* hw/rtl/mjdf_parser.sv */
`include "mjpeg_multipart_deframer_macros.svh"

module mjdf_parser #(
  parameter int LENGTH_WIDTH = mjdf_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  logic [7:0]                     byte_in,
  input  logic [mjdf_pkg::CFG_WIDTH-1:0] max_len,
  output mjdf_pkg::result_t              res
);
  import mjdf_pkg::*;

  localparam logic [2:0] PH_DASH   = 3'd0;
  localparam logic [2:0] PH_CR     = 3'd1;
  localparam logic [2:0] PH_KEY    = 3'd2;
  localparam logic [2:0] PH_SPACE  = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_LF     = 3'd5;
  localparam logic [2:0] PH_DATA   = 3'd6;

  localparam int MUL_W = LENGTH_WIDTH + 4;
  localparam int CMP_W = (LENGTH_WIDTH > CFG_WIDTH) ? LENGTH_WIDTH : CFG_WIDTH;

  logic [2:0]              phase, phase_next;
  logic [3:0]              match_pos, match_pos_next;
  logic [LENGTH_WIDTH-1:0] declared_len, declared_len_next;
  logic [LENGTH_WIDTH-1:0] remaining, remaining_next;
  logic                    newline_seen, newline_seen_next;
  logic                    digits_started, digits_started_next;

  logic [MUL_W-1:0]        len_times_ten;
  logic [3:0]              digit_val;
  logic [3:0]              match_inc;
  logic [LENGTH_WIDTH-1:0] remaining_dec;
  logic                    over_limit;
  logic [7:0]              digit_diff;

  assign digit_diff    = byte_in - CHAR_ZERO;
  assign digit_val     = digit_diff[3:0];
  assign len_times_ten = (MUL_W'(declared_len) << 3) + (MUL_W'(declared_len) << 1)
                         + MUL_W'(digit_val);
  assign match_inc     = match_pos + 4'd1;
  assign remaining_dec = remaining - LENGTH_WIDTH'(1);
  assign over_limit    = CMP_W'(declared_len) > CMP_W'(max_len);

  always_comb begin
    phase_next          = phase;
    match_pos_next      = match_pos;
    declared_len_next   = declared_len;
    remaining_next      = remaining;
    newline_seen_next   = newline_seen;
    digits_started_next = digits_started;
    res                 = '0;
    if (fire) begin
      case (phase)
        PH_CR: begin
          if (byte_in == CHAR_CR) begin
            phase_next     = PH_KEY;
            match_pos_next = 4'd0;
          end
        end
        PH_KEY: begin
          if (match_pos < KEY_LEN && byte_in == key_char(match_pos)) begin
            match_pos_next = match_inc;
            if (match_inc == KEY_LEN) begin
              phase_next     = PH_SPACE;
              match_pos_next = 4'd0;
            end
          end else begin
            match_pos_next = (byte_in == CHAR_C) ? 4'd1 : 4'd0;
          end
        end
        PH_SPACE: begin
          if (byte_in == CHAR_SPACE) begin
            phase_next          = PH_DIGITS;
            declared_len_next   = '0;
            digits_started_next = 1'b0;
            newline_seen_next   = 1'b0;
          end
        end
        PH_DIGITS: begin
          if (byte_in inside {[CHAR_ZERO:CHAR_NINE]}) begin
            // saturate at all ones
            if (len_times_ten[MUL_W-1:LENGTH_WIDTH] != '0) begin
              declared_len_next = '1;
            end else begin
              declared_len_next = len_times_ten[LENGTH_WIDTH-1:0];
            end
            digits_started_next = 1'b1;
          end else if (byte_in == CHAR_SPACE && !digits_started) begin
            phase_next = PH_DIGITS;
          end else if (over_limit) begin
            phase_next          = PH_DASH;
            match_pos_next      = 4'd0;
            newline_seen_next   = 1'b0;
            digits_started_next = 1'b0;
            res.valid           = 1'b1;
            res.length_error    = 1'b1;
          end else begin
            phase_next        = PH_LF;
            newline_seen_next = (byte_in == CHAR_LF);
          end
        end
        PH_LF: begin
          if (byte_in == CHAR_LF) begin
            if (!newline_seen) begin
              newline_seen_next = 1'b1;
            end else if (declared_len == '0) begin
              phase_next          = PH_DASH;
              match_pos_next      = 4'd0;
              newline_seen_next   = 1'b0;
              digits_started_next = 1'b0;
            end else begin
              remaining_next    = declared_len;
              phase_next        = PH_DATA;
              newline_seen_next = 1'b0;
            end
          end
        end
        PH_DATA: begin
          remaining_next   = remaining_dec;
          res.valid        = 1'b1;
          res.payload_byte = byte_in;
          res.frame_last   = (remaining_dec == '0);
          if (remaining_dec == '0) begin
            phase_next          = PH_DASH;
            match_pos_next      = 4'd0;
            newline_seen_next   = 1'b0;
            digits_started_next = 1'b0;
          end
        end
        default: begin
          phase_next = PH_DASH;
          if (byte_in == CHAR_DASH) begin
            if (match_pos == 4'd1) begin
              phase_next     = PH_CR;
              match_pos_next = 4'd0;
            end else begin
              match_pos_next = 4'd1;
            end
          end else begin
            match_pos_next = 4'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DASH;
      match_pos      <= 4'd0;
      declared_len   <= '0;
      remaining      <= '0;
      newline_seen   <= 1'b0;
      digits_started <= 1'b0;
    end else begin
      phase          <= phase_next;
      match_pos      <= match_pos_next;
      declared_len   <= declared_len_next;
      remaining      <= remaining_next;
      newline_seen   <= newline_seen_next;
      digits_started <= digits_started_next;
    end
  end

  `MJDF_ASSERT_IMPLIES(a_result_needs_fire, res.valid, fire)
  `MJDF_ASSERT_IMPLIES(a_data_has_count, phase == PH_DATA, remaining != '0)
  `MJDF_ASSERT_NEXT(a_error_rehunts, res.valid && res.length_error,
                    phase == PH_DASH && match_pos == 4'd0)
  `MJDF_ASSERT_NEVER(a_last_and_error, res.frame_last && res.length_error)

endmodule

/* hw/rtl/mjdf_out_queue.sv */
`include "mjpeg_multipart_deframer_macros.svh"

module mjdf_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  mjdf_pkg::result_t push_res,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        payload_byte,
  output logic              frame_last,
  output logic              length_error
);
  import mjdf_pkg::*;

  result_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push         = push_res.valid;
  assign full         = (count == 2'd2);
  assign out_valid    = (count != 2'd0);
  assign pop          = out_valid && !out_stall;
  assign payload_byte = entry[rd_ptr].payload_byte;
  assign frame_last   = entry[rd_ptr].frame_last;
  assign length_error = entry[rd_ptr].length_error;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `MJDF_ASSERT_NEVER(a_push_when_full, push && full)
  `MJDF_ASSERT_NEVER(a_count_range, count == 2'd3)
  `MJDF_ASSERT_NEXT(a_push_grows, push && !pop, count == $past(count) + 2'd1)

endmodule

/* tb/tb_mjpeg_multipart_deframer.sv */
`timescale 1ns / 100ps
module tb_mjpeg_multipart_deframer;
  import mjdf_pkg::*;

  localparam int LW = LENGTH_WIDTH_DEFAULT;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 145;
  localparam int PHASES = 6;

  typedef enum logic [2:0] {
    HUNT_DASH, SKIP_CR, MATCH_KEY, SKIP_SPACE, READ_DIGITS, WAIT_LF, PASS_DATA
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } frame_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           payload_byte;
  logic                 frame_last;
  logic                 length_error;
  logic                 cfg_write = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  mjpeg_multipart_deframer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .frame_last   (frame_last),
    .length_error (length_error),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [7:0]    stream_bytes [$];
  frame_result_t expected_results [$];
  int            bytes_made = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_requests = 0;
  int            hold_served = 0;
  int            hold_left = 0;
  int            error_count = 0;
  int            quiet_cycles = 0;
  logic [LW-1:0] length_limit = MAX_LEN_RESET;
  string         keyword_text = "Content-Length";

  parse_phase_t  phase = HUNT_DASH;
  logic [3:0]    match_pos = '0;
  logic [LW-1:0] declared_len = '0;
  logic [LW-1:0] remaining = '0;
  logic          nl_seen = 1'b0;
  logic          digits_seen = 1'b0;

  function automatic void restart_hunt();
    phase = HUNT_DASH;
    match_pos = '0;
    nl_seen = 1'b0;
    digits_seen = 1'b0;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    logic [63:0] acc;
    case (phase)
      SKIP_CR: begin
        if (b == CHAR_CR) begin
          phase = MATCH_KEY;
          match_pos = '0;
        end
      end
      MATCH_KEY: begin
        if (match_pos < KEY_LEN && b == keyword_text[match_pos]) begin
          match_pos = match_pos + 1'b1;
          if (match_pos == KEY_LEN) begin
            phase = SKIP_SPACE;
            match_pos = '0;
          end
        end else begin
          match_pos = (b == CHAR_C) ? 4'd1 : 4'd0;
        end
      end
      SKIP_SPACE: begin
        if (b == CHAR_SPACE) begin
          phase = READ_DIGITS;
          declared_len = '0;
          digits_seen = 1'b0;
          nl_seen = 1'b0;
        end
      end
      READ_DIGITS: begin
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
          acc = 64'(declared_len) * 64'd10 + 64'(b - CHAR_ZERO);
          declared_len = (acc > 64'({LW{1'b1}})) ? {LW{1'b1}} : acc[LW-1:0];
          digits_seen = 1'b1;
        end else if (!(b == CHAR_SPACE && !digits_seen)) begin
          if (declared_len > length_limit) begin
            restart_hunt();
            expected_results.push_back('{data: 8'h00, last: 1'b0, err: 1'b1});
          end else begin
            phase = WAIT_LF;
            nl_seen = (b == CHAR_LF);
          end
        end
      end
      WAIT_LF: begin
        if (b == CHAR_LF) begin
          if (!nl_seen) begin
            nl_seen = 1'b1;
          end else if (declared_len == '0) begin
            restart_hunt();
          end else begin
            remaining = declared_len;
            phase = PASS_DATA;
            nl_seen = 1'b0;
          end
        end
      end
      PASS_DATA: begin
        remaining = remaining - 1'b1;
        expected_results.push_back('{data: b, last: (remaining == '0), err: 1'b0});
        if (remaining == '0) restart_hunt();
      end
      default: begin
        phase = HUNT_DASH;
        if (b == CHAR_DASH) begin
          if (match_pos == 4'd1) begin
            phase = SKIP_CR;
            match_pos = '0;
          end else begin
            match_pos = 4'd1;
          end
        end else begin
          match_pos = '0;
        end
      end
    endcase
  endtask

  // Driver: advance to the next pending byte once the current one is transferred.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_byte <= stream_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_stall <= 1'b1;
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: check the output transfer first, then predict from the input transfer.
  always @(posedge clk) begin
    frame_result_t exp_res;
    if (rst) begin
      restart_hunt();
      declared_len = '0;
      remaining = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: payload_byte %0h, frame_last %0b, length_error %0b",
                 payload_byte, frame_last, length_error);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (payload_byte !== exp_res.data) begin
            $error("payload_byte: expected %0h, actual %0h", exp_res.data, payload_byte);
            error_count++;
          end
          if (frame_last !== exp_res.last) begin
            $error("frame_last: expected %0b, actual %0b", exp_res.last, frame_last);
            error_count++;
          end
          if (length_error !== exp_res.err) begin
            $error("length_error: expected %0b, actual %0b", exp_res.err, length_error);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) deframe_byte(in_byte);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void push_byte(input logic [7:0] b);
    stream_bytes.push_back(b);
    bytes_made++;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_random(input int n);
    repeat (n) push_byte(8'($urandom));
  endfunction

  // A negative forced_len picks a random length class: zero, no digits, good or over the limit.
  task automatic add_frame(input int forced_len);
    string      bnd;
    string      digits;
    string      key_text;
    longint     value;
    logic [7:0] term;
    int         pick;
    bit         fails;
    bnd = "";
    repeat ($urandom_range(1, 8)) bnd = {bnd, $sformatf("%c", 8'h61 + 8'($urandom_range(25)))};
    value = forced_len;
    fails = 1'b0;
    digits = "";
    if (forced_len < 0) begin
      pick = $urandom_range(99);
      if (pick >= 80 && length_limit != '1) begin
        fails = 1'b1;
        if ($urandom_range(1) == 1) digits = $sformatf("1%010d", $urandom_range(999999999));
        else value = longint'(length_limit) + 1 + $urandom_range(1000);
      end else if (pick < 10) begin
        value = ($urandom_range(1) == 1) ? 0 : -1;
      end else if (pick < 75) begin
        value = $urandom_range(1, 40);
      end else begin
        value = $urandom_range(1, 150);
      end
      if (!fails && value > longint'(length_limit)) value = longint'(length_limit);
    end
    if (digits == "" && value >= 0) begin
      digits = $sformatf("%0d", value);
      if ($urandom_range(3) == 0) digits = {"00", digits};
    end
    case ($urandom_range(5))
      0:       key_text = "CContent-Length";
      1:       key_text = "Content-Content-Length";
      2:       key_text = "Content-LengtContent-Length";
      default: key_text = "Content-Length";
    endcase
    push_text({"--", bnd, "\r\n"});
    if ($urandom_range(2) == 0) push_text("Content-Type: image/jpeg\r\n");
    push_text(key_text);
    if ($urandom_range(3) != 0) push_text(":");
    push_text(" ");
    repeat ($urandom_range(2)) push_text(" ");
    push_text(digits);
    case ($urandom_range(4))
      0:       term = CHAR_LF;
      1:       term = 8'h2B;
      2:       term = CHAR_DASH;
      3:       term = 8'h3B;
      default: term = CHAR_CR;
    endcase
    push_byte(term);
    if (term == CHAR_LF) push_text("\r\n");
    else push_text("\n\r\n");
    if (!fails && value > 0) push_random(int'(value));
  endtask

  task automatic wait_drained();
    while (stream_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [CFG_WIDTH-1:0] lim;
    string                hdr;
    int                   kind;
    int                   start;
    int                   cut;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 79;

    push_text("--\rContent-Length: 2\n\n");
    push_byte(8'h00);
    push_byte(8'hFF);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) begin
        send_idle_pct = 79;
        recv_idle_pct = 22;
      end
      if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        1:       lim = '0;
        2:       lim = '1;
        3:       lim = CFG_WIDTH'(1);
        4:       lim = CFG_WIDTH'($urandom_range(200));
        default: lim = MAX_LEN_RESET;
      endcase
      if (p != 0) begin
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= lim;
        @(posedge clk);
        cfg_write <= 1'b0;
        length_limit = lim;
      end
      if (p == PHASES - 1) begin
        add_frame(150);
        hold_requests++;
      end
      start = bytes_made;
      while (bytes_made - start < PHASE_BYTES) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          add_frame(-1);
        end else if (kind < 80) begin
          push_random($urandom_range(1, 8));
        end else if (kind < 90) begin
          hdr = "--bnd\r\nContent-Length";
          cut = $urandom_range(1, hdr.len() - 1);
          push_text(hdr.substr(0, cut - 1));
        end else begin
          case ($urandom_range(3))
            0:       push_text("-");
            1:       push_text("--");
            2:       push_text("--\r");
            default: push_text("-\r-");
          endcase
        end
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
